// File: rtl/swtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared types and constants of the sliding-window trimmed mean.
// ----------------------------------------------------------------------------
package swtm_pkg;

   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int LEN_W  = 7;
   localparam int TRIM_W = 5;

   localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = 7'd64;
   localparam logic [TRIM_W-1:0] TRIM_COUNT_RESET = 5'd1;

   localparam logic REG_WINDOW_LEN = 1'b0;
   localparam logic REG_TRIM_COUNT = 1'b1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_EVICT,
      OP_INSERT,
      OP_ROTATE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_INSERT,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } st_type;

endpackage

// File: rtl/swtm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_cell
// One slot of the sorted sample chain: value, age and occupancy.
// ----------------------------------------------------------------------------
module swtm_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int AGE_W       = 6,
   parameter int MAX_WINDOW  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swtm_pkg::op_type       op,
   input  logic [SAMPLE_BITS-1:0] new_sample,
   input  logic                   lo_valid,
   input  logic [AGE_W-1:0]       lo_age,
   input  logic [SAMPLE_BITS-1:0] lo_value,
   input  logic                   lo_gt,
   input  logic                   hi_valid,
   input  logic [AGE_W-1:0]       hi_age,
   input  logic [SAMPLE_BITS-1:0] hi_value,
   input  logic                   kill_in,
   output logic                   kill_out,
   output logic                   gt,
   output logic                   valid,
   output logic [AGE_W-1:0]       age,
   output logic [SAMPLE_BITS-1:0] value
);
   import swtm_pkg::*;

   localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(MAX_WINDOW - 1);

   logic                   valid_ff, valid_in;
   logic [AGE_W-1:0]       age_ff, age_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;

   assign kill_out = kill_in | (valid_ff & (age_ff == AGE_LAST));
   assign gt       = ~valid_ff | (value_ff > new_sample);

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      value_in = value_ff;
      case (op)
         OP_EVICT: begin
            if (kill_out) begin
               valid_in = hi_valid;
               age_in   = hi_age;
               value_in = hi_value;
            end
         end
         OP_INSERT: begin
            if (!gt) begin
               age_in = age_ff + 1'b1;
            end else if (lo_gt) begin
               valid_in = lo_valid;
               age_in   = lo_age + 1'b1;
               value_in = lo_value;
            end else begin
               valid_in = 1'b1;
               age_in   = '0;
               value_in = new_sample;
            end
         end
         OP_ROTATE: begin
            valid_in = hi_valid;
            age_in   = hi_age;
            value_in = hi_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      age_ff   <= age_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign age   = age_ff;
   assign value = value_ff;

endmodule

// File: rtl/swtm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtm_div #(
   parameter int SUM_W = 22,
   parameter int DIV_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   diff;

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/sliding_window_trimmed_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// Trimmed mean over the most recent samples, kept in a sorted cell chain.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: sample
// rsp      out  rsp_tvalid/tready    tdata: valid_res, average
// csr      in   csr_we               csr_index, csr_wdata
//
// Per sample: accept, evict, insert, scan (chain rotates once past cell 0),
// divide, then the move to the output register; invalid windows skip scan and
// divide. A full output register holds the block before that last step.
// Reset is synchronous; chain contents need no clearing.
// A pending result waits in the output register while the next sample enters.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean #(
   parameter int MAX_WINDOW  = swtm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+8)/8)*8-1:0]    rsp_tdata,  // valid_res, average
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [swtm_pkg::LEN_W-1:0]          csr_wdata
);
   import swtm_pkg::*;

   localparam int AGE_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + AGE_W;
   localparam int CW    = (CNT_W > LEN_W) ? CNT_W + 1 : LEN_W + 1;
   localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

   st_type state_ff, state_in;
   op_type op;

   logic [LEN_W-1:0]       len_ff;
   logic [TRIM_W-1:0]      trim_ff;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [AGE_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       rank_ff, rank_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [SAMPLE_BITS-1:0] rsp_avg_ff, rsp_avg_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;

   logic                   c_valid [MAX_WINDOW];
   logic [AGE_W-1:0]       c_age   [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] c_value [MAX_WINDOW];
   logic                   c_gt    [MAX_WINDOW];
   logic                   c_kill  [MAX_WINDOW];

   logic                   top_valid;
   logic [AGE_W-1:0]       top_age;
   logic [SAMPLE_BITS-1:0] top_value;

   logic                   div_start, div_done;
   logic [SUM_W-1:0]       div_quo;
   logic [CNT_W-1:0]       n_div;
   logic [CW-1:0]          len_x, trim2_x, fill_x, rank_x, hi_x;
   logic                   ok_now, in_win;

   assign top_valid = (op == OP_ROTATE) ? c_valid[0] : 1'b0;
   assign top_age   = c_age[0];
   assign top_value = c_value[0];

   genvar k;
   generate
      for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
         swtm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .AGE_W      (AGE_W),
            .MAX_WINDOW (MAX_WINDOW)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .op        (op),
            .new_sample(sample_ff),
            .lo_valid  ((k == 0) ? 1'b0 : c_valid[(k == 0) ? 0 : k - 1]),
            .lo_age    (c_age[(k == 0) ? 0 : k - 1]),
            .lo_value  (c_value[(k == 0) ? 0 : k - 1]),
            .lo_gt     ((k == 0) ? 1'b0 : c_gt[(k == 0) ? 0 : k - 1]),
            .hi_valid  ((k == MAX_WINDOW - 1) ? top_valid
                                              : c_valid[(k == MAX_WINDOW - 1) ? k : k + 1]),
            .hi_age    ((k == MAX_WINDOW - 1) ? top_age
                                              : c_age[(k == MAX_WINDOW - 1) ? k : k + 1]),
            .hi_value  ((k == MAX_WINDOW - 1) ? top_value
                                              : c_value[(k == MAX_WINDOW - 1) ? k : k + 1]),
            .kill_in   ((k == 0) ? 1'b0 : c_kill[(k == 0) ? 0 : k - 1]),
            .kill_out  (c_kill[k]),
            .gt        (c_gt[k]),
            .valid     (c_valid[k]),
            .age       (c_age[k]),
            .value     (c_value[k])
         );
      end
   endgenerate

   assign n_div = CNT_W'(len_x - trim2_x);

   swtm_div #(
      .SUM_W(SUM_W),
      .DIV_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_in),
      .divisor (n_div),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign len_x   = CW'(len_ff);
   assign trim2_x = CW'({trim_ff, 1'b0});
   assign fill_x  = CW'(fill_ff);
   assign rank_x  = CW'(rank_ff);
   assign hi_x    = len_x - CW'(trim_ff);
   assign ok_now  = (len_x <= CW'(MAX_WINDOW)) && (trim2_x < len_x) && (fill_x >= len_x);
   assign in_win  = c_valid[0] && (CW'(c_age[0]) < len_x);

   always_comb begin
      state_in     = state_ff;
      op           = OP_HOLD;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      rank_in      = rank_ff;
      sum_in       = sum_ff;
      ok_in        = ok_ff;
      avg_in       = avg_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_avg_in   = rsp_avg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            op = OP_EVICT;
            if (fill_ff != CNT_W'(MAX_WINDOW)) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            op      = OP_INSERT;
            ok_in   = ok_now;
            scan_in = '0;
            rank_in = '0;
            sum_in  = '0;
            avg_in  = '0;
            state_in = ok_now ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            op = OP_ROTATE;
            if (in_win) begin
               rank_in = rank_ff + 1'b1;
               if (rank_x >= CW'(trim_ff) && rank_x < hi_x) begin
                  sum_in = sum_ff + SUM_W'(c_value[0]);
               end
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == AGE_W'(MAX_WINDOW - 1)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quo[SAMPLE_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_avg_in   = avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= WINDOW_LEN_RESET;
         trim_ff      <= TRIM_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_WINDOW_LEN: len_ff  <= csr_wdata;
               REG_TRIM_COUNT: trim_ff <= csr_wdata[TRIM_W-1:0];
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      scan_ff    <= scan_in;
      rank_ff    <= rank_in;
      sum_ff     <= sum_in;
      ok_ff      <= ok_in;
      avg_ff     <= avg_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_avg_ff, rsp_ok_ff});

`ifndef SYNTHESIS
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_WINDOW))
      else $error("fill count beyond storage");
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_avg_ff == '0)
      else $error("nonzero average on invalid result");
   a_insert_fills_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |=> c_valid[0])
      else $error("chain head empty after insert");
`endif

endmodule

// File: sim/sliding_window_trimmed_mean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_checker
// Watches the sample and result channels and predicts each trimmed mean from
// its own copy of the sample ring and the window settings. Every result is
// compared field by field with the oldest prediction; failures are counted.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   output int          fail_count,
   output int          pending_means
);
   import swtm_pkg::*;

   typedef struct packed {
      logic [15:0] average;
      logic        valid_res;
   } mean_type;

   logic [LEN_W-1:0]  win_len;
   logic [TRIM_W-1:0] trim;
   logic [15:0]       ring [64];
   int                fill;
   int                wr_ptr;
   mean_type          mean_q [$];

   function automatic mean_type trimmed_mean();
      logic [15:0] srt [64];
      logic [15:0] key;
      logic [21:0] sum;
      mean_type    m;
      int          j;
      m = '0;
      if (win_len > 64 || 2 * trim >= win_len || fill < win_len) return m;
      for (int i = 0; i < win_len; i++) srt[i] = ring[(wr_ptr + 63 - i) % 64];
      for (int i = 1; i < win_len; i++) begin
         key = srt[i];
         j = i;
         while (j > 0 && srt[j-1] > key) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = key;
      end
      sum = '0;
      for (int i = trim; i < win_len - trim; i++) sum += srt[i];
      m.valid_res = 1'b1;
      m.average   = 16'(sum / (win_len - 2 * trim));
      return m;
   endfunction

   always @(posedge clock) begin
      mean_type got, want;
      int       errs;
      errs = 0;
      if (reset) begin
         win_len <= WINDOW_LEN_RESET;
         trim    <= TRIM_COUNT_RESET;
         fill    = 0;
         wr_ptr  = 0;
         mean_q.delete();
         fail_count    <= 0;
         pending_means <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_WINDOW_LEN) win_len <= csr_wdata;
            else trim <= csr_wdata[TRIM_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = mean_type'(rsp_tdata[16:0]);
            if (mean_q.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               errs++;
            end else begin
               want = mean_q.pop_front();
               if (got.valid_res !== want.valid_res) begin
                  $error("valid_res expected %0d actual %0d", want.valid_res, got.valid_res);
                  errs++;
               end
               if (got.average !== want.average) begin
                  $error("average expected %0d actual %0d", want.average, got.average);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            ring[wr_ptr] = req_tdata;
            wr_ptr = (wr_ptr + 1) % 64;
            if (fill < 64) fill++;
            mean_q.push_back(trimmed_mean());
         end
         fail_count    <= fail_count + errs;
         pending_means <= mean_q.size();
      end
   end
endmodule

// File: sim/sliding_window_trimmed_mean_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_tb
// Drives samples through several window and trim settings, with random gaps
// and result stalls; the checker predicts and compares every trimmed mean.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_tb;
   import swtm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // valid_res, average
   logic        csr_we;
   logic        csr_index;
   logic [6:0]  csr_wdata;
   int          fail_count;
   int          pending_means;
   int          idle_cycles;
   bit          calm;
   bit          timed_out;

   sliding_window_trimmed_mean i_dut (.*);

   sliding_window_trimmed_mean_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hold off results in random bursts.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      timed_out = 1'b0;
      wait (idle_cycles >= WATCHDOG_LIMIT);
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_sample(input logic [15:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_means == 0 || timed_out);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [6:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      logic [15:0] v;
      for (int i = 0; i < count && !timed_out; i++) begin
         case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'(8'($urandom_range(0, 3)));
            default: v = 16'($urandom);
         endcase
         send_sample(v);
      end
   endtask

   initial begin
      int lens [8]  = '{3, 64, 5, 17, 64, 9, 127, 32};
      int trims [8] = '{1, 31, 0, 2, 1, 4, 3, 16};
      reset      = 1'b1;
      calm       = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_WINDOW_LEN;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed: part-fill the default window with extremes and ties.
      for (int i = 0; i < 20 && !timed_out; i++)
         send_sample((i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'h8000);
      drain();
      for (int p = 0; p < 8 && !timed_out; p++) begin
         write_csr(REG_WINDOW_LEN, 7'(lens[p]));
         write_csr(REG_TRIM_COUNT, 7'(trims[p]));
         if (p == 7) calm = 1'b1;
         random_phase(p == 1 ? 120 : 170);
         drain();
      end
      if (timed_out) $display("*** FAILED ***");
      else if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: files.f
rtl/swtm_pkg.sv
rtl/swtm_cell.sv
rtl/swtm_div.sv
rtl/sliding_window_trimmed_mean.sv
sim/sliding_window_trimmed_mean_checker.sv
sim/sliding_window_trimmed_mean_tb.sv
